### design/iht_pkg.sv
`default_nettype none

package iht_pkg;

  localparam int NUM_BUTTONS_DEF = 12;
  localparam int NUM_AXES_DEF    = 6;
  localparam int LINE_COUNT_DEF  = 64;
  localparam int COUNT_BITS_DEF  = 32;

  localparam int LINE_W     = 64;
  localparam int AXIS_W     = 16;
  localparam int RAW_AXES   = 6;
  localparam int SCALED_W   = 24;
  localparam int HOLD_W     = 32;
  localparam int SLOT_OUT_W = 4;

  localparam int MODE_W     = 2;
  localparam int MAP_W      = 42;
  localparam int DKEY_W     = 28;
  localparam int THR_W      = 15;
  localparam int CFG_DATA_W = 42;
  localparam int CFG_IDX_W  = 3;

  localparam int ENTRY_W     = 7;
  localparam int MAP_BUTTONS = 6;
  localparam int ALL_BUTTONS = 2 * MAP_BUTTONS;
  localparam int DIR_SLOTS   = 2;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(500);

  // Q7.16 scaling by 65536/1000: floor(u * RECIP / 2^SHIFT) is exact for |u| <= 32768.
  localparam int PROD_W       = 45;
  localparam int RECIP_W      = 29;
  localparam int RECIP_SHIFT  = 22;
  localparam int QUOT_W       = 22;
  localparam logic [RECIP_W-1:0] AXIS_RECIP = RECIP_W'(274877907);

  localparam logic [SCALED_W-1:0] AX_ONE       = SCALED_W'(24'h010000);
  localparam logic [SCALED_W-1:0] AX_MINUS_ONE = SCALED_W'(24'hFF0000);

  typedef enum logic [MODE_W-1:0] {
    MODE_DISABLED   = 2'd0,
    MODE_CONTROLLER = 2'd1,
    MODE_KEYBOARD   = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_MODE     = 3'd0,
    REG_BUTTON_MAP_LOW  = 3'd1,
    REG_BUTTON_MAP_HIGH = 3'd2,
    REG_DIRECTION_KEYS  = 3'd3,
    REG_AXIS_THRESHOLD  = 3'd4
  } cfg_reg_e;

  typedef logic [RAW_AXES-1:0][AXIS_W-1:0] axis_arr_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [MAP_W-1:0]  map_lo;
    logic [MAP_W-1:0]  map_hi;
    logic [DKEY_W-1:0] dir_keys;
    logic [THR_W-1:0]  thr;
  } cfg_t;

  typedef struct packed {
    logic              present;
    logic [LINE_W-1:0] lines;
    axis_arr_t         axes;
  } req_t;

  function automatic logic [AXIS_W-1:0] raw_axis(input axis_arr_t axes, input logic [2:0] idx);
    logic [AXIS_W-1:0] v;
    v = '0;
    if (32'(idx) < RAW_AXES) begin
      v = axes[idx];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### design/iht_req_if.sv
`default_nettype none

interface iht_req_if
  import iht_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              controller_present;
  logic [LINE_W-1:0] pressed_lines;
  logic signed [AXIS_W-1:0] axis_0;
  logic signed [AXIS_W-1:0] axis_1;
  logic signed [AXIS_W-1:0] axis_2;
  logic signed [AXIS_W-1:0] axis_3;
  logic signed [AXIS_W-1:0] axis_4;
  logic signed [AXIS_W-1:0] axis_5;

  modport source (
    output valid, controller_present, pressed_lines,
    output axis_0, axis_1, axis_2, axis_3, axis_4, axis_5,
    input  ready
  );

  modport sink (
    input  valid, controller_present, pressed_lines,
    input  axis_0, axis_1, axis_2, axis_3, axis_4, axis_5,
    output ready
  );
endinterface

`default_nettype wire

### design/iht_rsp_if.sv
`default_nettype none

interface iht_rsp_if
  import iht_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic [SLOT_OUT_W-1:0]       slot;
  logic signed [HOLD_W-1:0]    hold_count;
  logic                        released;
  logic signed [SCALED_W-1:0]  scaled_axis;
  logic                        last;

  modport source (
    output valid, slot, hold_count, released, scaled_axis, last,
    input  ready
  );

  modport sink (
    input  valid, slot, hold_count, released, scaled_axis, last,
    output ready
  );
endinterface

`default_nettype wire

### design/iht_store.sv
`default_nettype none

module iht_store
  import iht_pkg::*;
#(
  parameter int WIDTH = 33,
  parameter int DEPTH = 14
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     clr_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output      logic [WIDTH-1:0]         rd_data_o,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= vld_q[rd_addr_i] ? mem[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

### design/iht_scaler.sv
`default_nettype none

module iht_scaler
  import iht_pkg::*;
#(
  parameter int NUM_AXES = NUM_AXES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire axis_arr_t                   axes_i,
  input  wire logic [$clog2(NUM_AXES)-1:0] idx_i,
  output      logic [SCALED_W-1:0]         scaled_o
);

  logic [AXIS_W-1:0]   raw;
  logic [AXIS_W-1:0]   mag;
  logic [PROD_W-1:0]   prod_q;
  logic                neg_q;
  logic [SCALED_W-1:0] quot;

  assign raw = raw_axis(axes_i, 3'(idx_i));
  assign mag = raw[AXIS_W-1] ? (~raw + AXIS_W'(1)) : raw;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(mag) * PROD_W'(AXIS_RECIP);
      neg_q  <= raw[AXIS_W-1];
    end
  end

  assign quot     = SCALED_W'(prod_q[RECIP_SHIFT +: QUOT_W]);
  assign scaled_o = neg_q ? (~quot + SCALED_W'(1)) : quot;

endmodule

`default_nettype wire

### design/iht_slot_calc.sv
`default_nettype none

module iht_slot_calc
  import iht_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int NUM_AXES    = NUM_AXES_DEF,
  parameter int LINE_COUNT  = LINE_COUNT_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int IDX_W       = 4
) (
  input  wire cfg_t                  cfg_i,
  input  wire req_t                  req_i,
  input  wire logic [IDX_W-1:0]      slot_i,
  input  wire logic [COUNT_BITS-1:0] cnt_i,
  input  wire logic                  flag_i,
  input  wire logic [SCALED_W-1:0]   ax_i,
  input  wire logic [SCALED_W-1:0]   scaled_i,
  output      logic                  cnt_we_o,
  output      logic [COUNT_BITS-1:0] cnt_o,
  output      logic                  flag_o,
  output      logic                  ax_we_o,
  output      logic [SCALED_W-1:0]   ax_o
);

  localparam int CW = COUNT_BITS;

  function automatic logic line_pressed(input logic [LINE_W-1:0] lines,
                                        input logic [ENTRY_W-1:0] entry);
    logic [5:0] idx;
    idx = entry[5:0];
    return (32'(idx) < 32'(LINE_COUNT)) && lines[idx];
  endfunction

  function automatic logic [CW:0] dir_step(input logic [CW-1:0] c, input logic up,
                                           input logic down);
    logic          nz;
    logic          pos;
    logic [CW-1:0] n;
    nz  = |c;
    pos = nz && !c[CW-1];
    n   = c;
    if (!up && !down) begin
      n = '0;
    end else begin
      if ((down && pos) || (up && c[CW-1])) begin
        n = '0;
      end
      n = up ? (n + CW'(1)) : (n - CW'(1));
    end
    return {!up && !down && nz, n};
  endfunction

  function automatic logic [CW:0] btn_step(input logic [CW-1:0] c, input logic p);
    logic pos;
    pos = (|c) && !c[CW-1];
    return {!p && pos, p ? (c + CW'(1)) : CW'(0)};
  endfunction

  logic [ENTRY_W-1:0] entries [ALL_BUTTONS];
  logic [IDX_W-1:0]   btn_idx;
  logic [ENTRY_W-1:0] btn_entry;
  logic               is_dir;
  logic               ax_in_range;
  logic               axis_sel;
  logic [AXIS_W-1:0]  v;
  logic signed [AXIS_W:0] v_ext;
  logic signed [AXIS_W:0] thr_ext;
  logic               v_up;
  logic               v_down;
  logic [ENTRY_W-1:0] neg_key;
  logic [ENTRY_W-1:0] pos_key;
  logic               keys_ok;
  logic               k_down;
  logic               k_up;
  logic               btn_p;
  logic [CW:0]        dir_pad;
  logic [CW:0]        dir_key;
  logic [CW:0]        btn_res;

  always_comb begin
    for (int k = 0; k < MAP_BUTTONS; k++) begin
      entries[k]               = cfg_i.map_lo[ENTRY_W*k +: ENTRY_W];
      entries[k + MAP_BUTTONS] = cfg_i.map_hi[ENTRY_W*k +: ENTRY_W];
    end
  end

  assign is_dir      = 32'(slot_i) < DIR_SLOTS;
  assign ax_in_range = 32'(slot_i) < 32'(NUM_AXES);
  assign axis_sel    = slot_i[0];

  assign btn_idx   = slot_i - IDX_W'(DIR_SLOTS);
  assign btn_entry = (!is_dir && 32'(btn_idx) < ALL_BUTTONS) ? entries[4'(btn_idx)] : '0;
  assign btn_p     = line_pressed(req_i.lines, btn_entry);

  assign v       = axis_sel ? req_i.axes[1] : req_i.axes[0];
  assign v_ext   = $signed({v[AXIS_W-1], v});
  assign thr_ext = $signed({2'b00, cfg_i.thr});
  assign v_down  = v_ext < -thr_ext;
  assign v_up    = v_ext > thr_ext;

  assign neg_key = axis_sel ? cfg_i.dir_keys[ENTRY_W +: ENTRY_W] : cfg_i.dir_keys[0 +: ENTRY_W];
  assign pos_key = axis_sel ? cfg_i.dir_keys[3*ENTRY_W +: ENTRY_W]
                            : cfg_i.dir_keys[2*ENTRY_W +: ENTRY_W];
  assign keys_ok = neg_key[ENTRY_W-1] && pos_key[ENTRY_W-1];
  assign k_down  = line_pressed(req_i.lines, neg_key);
  assign k_up    = !k_down && line_pressed(req_i.lines, pos_key);

  assign dir_pad = dir_step(cnt_i, v_up, v_down);
  assign dir_key = dir_step(cnt_i, k_up, k_down);
  assign btn_res = btn_step(cnt_i, btn_p);

  always_comb begin
    cnt_we_o = 1'b0;
    cnt_o    = cnt_i;
    flag_o   = flag_i;
    ax_we_o  = 1'b0;
    ax_o     = ax_i;
    if (cfg_i.mode == MODE_CONTROLLER && req_i.present) begin
      if (is_dir) begin
        cnt_we_o        = 1'b1;
        {flag_o, cnt_o} = dir_pad;
      end else if (btn_entry[ENTRY_W-1]) begin
        cnt_we_o        = 1'b1;
        {flag_o, cnt_o} = btn_res;
      end
      if (ax_in_range) begin
        ax_we_o = 1'b1;
        ax_o    = scaled_i;
      end
    end else if (cfg_i.mode == MODE_KEYBOARD) begin
      if (is_dir) begin
        if (keys_ok) begin
          cnt_we_o        = 1'b1;
          {flag_o, cnt_o} = dir_key;
          ax_we_o         = 1'b1;
          ax_o            = k_down ? AX_MINUS_ONE : (k_up ? AX_ONE : '0);
        end
      end else begin
        if (btn_entry[ENTRY_W-1]) begin
          cnt_we_o        = 1'b1;
          {flag_o, cnt_o} = btn_res;
        end
        if (ax_in_range) begin
          ax_we_o = 1'b1;
          ax_o    = '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/input_hold_release_tracker.sv
`default_nettype none
// Channel  Dir  Handshake             Payload
// req_i    in   valid/ready           controller_present, pressed_lines, axis_0..axis_5
// rsp_o    out  valid/ready           slot, hold_count, released, scaled_axis, last
// cfg      in   cfg_we_i (no stall)   cfg_idx_i, cfg_wdata_i
//
// One request yields NUM_BUTTONS+2 responses, one per slot, in slot order.
// Each slot is issued to a counter-store read, an axis-store read and the scaler, is then
// updated in the read stage and registered on rsp_o, and the update is written back.
// A new request is taken only after the last response of the previous one is taken.
// Reset restores the configuration defaults and clears the store valid bits; no clearing pass is run.
// A stalled response holds the slot pipeline; no state is lost.

module input_hold_release_tracker
  import iht_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int NUM_AXES    = NUM_AXES_DEF,
  parameter int LINE_COUNT  = LINE_COUNT_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  iht_req_if.sink                    req_i,
  iht_rsp_if.source                  rsp_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int SLOTS  = NUM_BUTTONS + DIR_SLOTS;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int AX_W   = $clog2(NUM_AXES);
  localparam int IDX_W  = (SLOT_W > AX_W) ? SLOT_W : AX_W;
  localparam int CW     = COUNT_BITS;

  cfg_t cfg_q;
  req_t item_q;

  logic             busy_q;
  logic             iss_done_q;
  logic [IDX_W-1:0] iss_q;
  logic             r_vld_q;
  logic [IDX_W-1:0] c_slot_q;

  logic                         out_vld_q;
  logic [SLOT_OUT_W-1:0]        out_slot_q;
  logic [HOLD_W-1:0]            out_cnt_q;
  logic                         out_flag_q;
  logic [SCALED_W-1:0]          out_ax_q;
  logic                         out_last_q;

  logic accept;
  logic take;
  logic advance;
  logic issue;
  logic clr;

  logic [CW:0]           cnt_rd;
  logic [SCALED_W-1:0]   ax_rd;
  logic [SCALED_W-1:0]   scaled;
  logic                  cnt_we;
  logic [CW-1:0]         cnt_new;
  logic                  flag_new;
  logic                  ax_we;
  logic [SCALED_W-1:0]   ax_new;

  assign accept  = req_i.valid && !busy_q;
  assign take    = out_vld_q && rsp_o.ready;
  assign advance = r_vld_q && (!out_vld_q || rsp_o.ready);
  assign issue   = busy_q && !iss_done_q && (!r_vld_q || advance);
  assign clr     = accept && cfg_q.mode != MODE_CONTROLLER && cfg_q.mode != MODE_KEYBOARD;

  assign req_i.ready = !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= MODE_DISABLED;
      cfg_q.map_lo   <= '0;
      cfg_q.map_hi   <= '0;
      cfg_q.dir_keys <= '0;
      cfg_q.thr      <= THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SOURCE_MODE:     cfg_q.mode     <= cfg_wdata_i[MODE_W-1:0];
        REG_BUTTON_MAP_LOW:  cfg_q.map_lo   <= cfg_wdata_i[MAP_W-1:0];
        REG_BUTTON_MAP_HIGH: cfg_q.map_hi   <= cfg_wdata_i[MAP_W-1:0];
        REG_DIRECTION_KEYS:  cfg_q.dir_keys <= cfg_wdata_i[DKEY_W-1:0];
        REG_AXIS_THRESHOLD:  cfg_q.thr      <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.present <= req_i.controller_present;
      item_q.lines   <= req_i.pressed_lines;
      item_q.axes    <= {req_i.axis_5, req_i.axis_4, req_i.axis_3,
                         req_i.axis_2, req_i.axis_1, req_i.axis_0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      iss_done_q <= 1'b0;
      iss_q      <= '0;
      r_vld_q    <= 1'b0;
      c_slot_q   <= '0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q     <= 1'b1;
        iss_done_q <= 1'b0;
        iss_q      <= '0;
      end else if (take && out_last_q) begin
        busy_q <= 1'b0;
      end
      if (issue) begin
        r_vld_q  <= 1'b1;
        c_slot_q <= iss_q;
        if (iss_q == IDX_W'(SLOTS - 1)) begin
          iss_done_q <= 1'b1;
        end else begin
          iss_q <= iss_q + IDX_W'(1);
        end
      end else if (advance) begin
        r_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q  <= 1'b1;
        out_last_q <= c_slot_q == IDX_W'(SLOTS - 1);
      end else if (take) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_slot_q <= SLOT_OUT_W'(c_slot_q);
      out_cnt_q  <= HOLD_W'($signed(cnt_new));
      out_flag_q <= flag_new;
      out_ax_q   <= (32'(c_slot_q) < 32'(NUM_AXES)) ? ax_new : '0;
    end
  end

  iht_store #(
    .WIDTH (CW + 1),
    .DEPTH (SLOTS)
  ) u_cnt_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (clr),
    .rd_en_i   (issue),
    .rd_addr_i (iss_q[SLOT_W-1:0]),
    .rd_data_o (cnt_rd),
    .we_i      (advance && cnt_we),
    .wr_addr_i (c_slot_q[SLOT_W-1:0]),
    .wr_data_i ({flag_new, cnt_new})
  );

  iht_store #(
    .WIDTH (SCALED_W),
    .DEPTH (NUM_AXES)
  ) u_ax_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (clr),
    .rd_en_i   (issue),
    .rd_addr_i (iss_q[AX_W-1:0]),
    .rd_data_o (ax_rd),
    .we_i      (advance && ax_we),
    .wr_addr_i (c_slot_q[AX_W-1:0]),
    .wr_data_i (ax_new)
  );

  iht_scaler #(
    .NUM_AXES (NUM_AXES)
  ) u_scaler (
    .clk_i    (clk_i),
    .en_i     (issue),
    .axes_i   (item_q.axes),
    .idx_i    (iss_q[AX_W-1:0]),
    .scaled_o (scaled)
  );

  iht_slot_calc #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .NUM_AXES    (NUM_AXES),
    .LINE_COUNT  (LINE_COUNT),
    .COUNT_BITS  (COUNT_BITS),
    .IDX_W       (IDX_W)
  ) u_calc (
    .cfg_i    (cfg_q),
    .req_i    (item_q),
    .slot_i   (c_slot_q),
    .cnt_i    (cnt_rd[CW-1:0]),
    .flag_i   (cnt_rd[CW]),
    .ax_i     (ax_rd),
    .scaled_i (scaled),
    .cnt_we_o (cnt_we),
    .cnt_o    (cnt_new),
    .flag_o   (flag_new),
    .ax_we_o  (ax_we),
    .ax_o     (ax_new)
  );

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.slot        = out_slot_q;
  assign rsp_o.hold_count  = out_cnt_q;
  assign rsp_o.released    = out_flag_q;
  assign rsp_o.scaled_axis = out_ax_q;
  assign rsp_o.last        = out_last_q;

endmodule

`default_nettype wire

### design/iht_checker.sv
`default_nettype none

module iht_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        req_valid_i,
  input wire logic        req_ready_i,
  input wire logic        rsp_valid_i,
  input wire logic        rsp_ready_i,
  input wire logic [3:0]  rsp_slot_i,
  input wire logic [31:0] rsp_hold_count_i,
  input wire logic        rsp_last_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while a run is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !rsp_valid_i)
    else $error("response shown right after request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_ready_i && !rsp_last_i |=> !req_ready_i)
    else $error("request open before run ends");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_slot_i) && $stable(rsp_hold_count_i))
    else $error("stalled response changed");

endmodule

bind input_hold_release_tracker iht_checker u_iht_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_slot_i       (rsp_o.slot),
  .rsp_hold_count_i (rsp_o.hold_count),
  .rsp_last_i       (rsp_o.last)
);

`default_nettype wire
